[hw/rtl/trppe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trppe_pkg
// Shared types, constants and helpers of the tile row planar pixel expander.
// ----------------------------------------------------------------------------
package trppe_pkg;

   localparam int NUM_PALETTES = 8;
   localparam int RAM_DEPTH    = 32;
   localparam int RAM_AW       = $clog2(RAM_DEPTH);
   localparam int PIX_PER_ROW  = 8;
   localparam int CNT_W        = $clog2(PIX_PER_ROW);
   localparam int PAL_W        = RAM_AW - 2;

   localparam logic [7:0] PAL_LIMIT = 8'((NUM_PALETTES < 8) ? NUM_PALETTES : 8);

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 2;

   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_DECODE = 1'b1;

   localparam logic [1:0] DEPTH_ONE = 2'd1;
   localparam logic [1:0] FMT_GRAY  = 2'd0;
   localparam logic [1:0] FMT_INDEX = 2'd1;

   localparam logic [7:0] FLIP_MASK = 8'h20;
   localparam logic [7:0] PAL_MASK  = 8'h07;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIT_DEPTH    = 2'd0,
      CSR_PIXEL_FORMAT = 2'd1,
      CSR_BASE_PALETTE = 2'd2,
      CSR_USE_MAP      = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic        action;
      logic [31:0] color_value;
      logic [4:0]  color_address;
      logic [7:0]  palette_map_value;
      logic [7:0]  attribute;
      logic [7:0]  plane_high;
      logic [7:0]  plane_low;
   } req_item_type;

   typedef struct packed {
      logic              is_wr;
      logic [RAM_AW-1:0] addr;
      logic [31:0]       wdata;
      logic [1:0]        cid;
      logic              err;
      logic              last;
   } pix_beat_type;

   typedef struct packed {
      logic [RAM_AW-1:0] addr;
      logic [31:0]       rdata;
      logic [1:0]        cid;
      logic              err;
      logic              last;
   } pix_read_type;

   function automatic logic [7:0] mirror8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = b[7-i];
      end
      return r;
   endfunction

endpackage

[hw/rtl/tile_row_planar_pixel_expander_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_row_planar_pixel_expander_top
// Expands planar tile rows into eight palette-mapped pixels, one per beat.
// ----------------------------------------------------------------------------
// path: a request passes the input, serialiser, ram, read data and output
// registers; the serialiser loads the next row as it hands on the last pixel,
// and hands one pixel or palette write a cycle to the ram port unless stalled
// reset: pipeline valids, row counter and config registers cleared to defaults
// (bit_depth 2, all others 0); the palette ram is not cleared
// ----------------------------------------------------------------------------
module tile_row_planar_pixel_expander_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // plane_low, plane_high, attribute, palette_map_value, color_address,
   // color_value, zero pad
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [trppe_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                 req_tuser,   // action
   // color_id, pixel_value, zero pad
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [trppe_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                 rsp_tuser,   // palette_error
   output logic                                 rsp_tlast,   // last_pixel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [trppe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [trppe_pkg::CSR_DATA_W-1:0]     csr_data
);

   // config
   logic [1:0] bit_depth_ff;
   logic [1:0] pixel_format_ff;
   logic [7:0] base_palette_ff;
   logic       use_map_ff;

   // stage 0: input register
   logic                    s0_v_ff, s0_v_in;
   trppe_pkg::req_item_type s0_ff;

   // stage 1: row serialiser
   logic                               s1_v_ff, s1_v_in;
   logic [trppe_pkg::CNT_W-1:0]        s1_cnt_ff, s1_cnt_in;
   logic                               s1_is_wr_ff;
   logic [7:0]                         s1_p0_ff, s1_p1_ff;
   logic [trppe_pkg::PAL_W-1:0]        s1_pal_ff;
   logic                               s1_err_ff;
   logic [trppe_pkg::RAM_AW-1:0]       s1_waddr_ff;
   logic [31:0]                        s1_wdata_ff;

   // stage 2: palette ram access
   logic                    s2_v_ff, s2_v_in;
   trppe_pkg::pix_beat_type s2_ff, s2_in;

   // stage 3: read data
   logic                    s3_v_ff, s3_v_in;
   trppe_pkg::pix_read_type s3_ff;

   // stage 4: output register
   logic        s4_v_ff, s4_v_in;
   logic [1:0]  s4_cid_ff;
   logic [31:0] s4_pv_ff, s4_pv_in;
   logic        s4_err_ff;
   logic        s4_last_ff;

   logic [31:0] pal_ram [trppe_pkg::RAM_DEPTH];

   logic s0_rdy, s1_emit, s1_done, s1_load;
   logic s2_go, s2_rdy, s3_go, s3_rdy, s4_rdy;
   logic req_acc, rsp_acc;

   logic       depth_one;
   logic [7:0] ld_p0, ld_p1, ld_sel, ld_pal;
   logic       ld_err;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_depth_ff    <= 2'd2;
         pixel_format_ff <= trppe_pkg::FMT_GRAY;
         base_palette_ff <= 8'd0;
         use_map_ff      <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (trppe_pkg::csr_idx_type'(csr_index))
            trppe_pkg::CSR_BIT_DEPTH:    bit_depth_ff    <= csr_data[1:0];
            trppe_pkg::CSR_PIXEL_FORMAT: pixel_format_ff <= csr_data[1:0];
            trppe_pkg::CSR_BASE_PALETTE: base_palette_ff <= csr_data;
            trppe_pkg::CSR_USE_MAP:      use_map_ff      <= csr_data[0];
         endcase
      end
   end

   assign depth_one = (bit_depth_ff == trppe_pkg::DEPTH_ONE);

   // handshake chain
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign s4_rdy     = !s4_v_ff || rsp_tready;
   assign s3_go      = s3_v_ff && s4_rdy;
   assign s3_rdy     = !s3_v_ff || s3_go;
   assign s2_go      = s2_v_ff && (s2_ff.is_wr || s3_rdy);
   assign s2_rdy     = !s2_v_ff || s2_go;
   assign s1_emit    = s1_v_ff && s2_rdy;
   assign s1_done    = s1_is_wr_ff || (s1_cnt_ff == trppe_pkg::CNT_W'(trppe_pkg::PIX_PER_ROW - 1));
   assign s1_load    = s0_v_ff && (!s1_v_ff || (s1_emit && s1_done));
   assign s0_rdy     = !s0_v_ff || s1_load;
   assign req_tready = s0_rdy;

   always_comb begin
      s0_v_in  = req_acc ? 1'b1 : (s1_load ? 1'b0 : s0_v_ff);
      s1_v_in  = s1_load ? 1'b1 : ((s1_emit && s1_done) ? 1'b0 : s1_v_ff);
      if (s1_load || (s1_emit && s1_done)) begin
         s1_cnt_in = '0;
      end else if (s1_emit) begin
         s1_cnt_in = s1_cnt_ff + 1'b1;
      end else begin
         s1_cnt_in = s1_cnt_ff;
      end
      s2_v_in = s1_emit ? 1'b1 : (s2_go ? 1'b0 : s2_v_ff);
      s3_v_in = (s2_go && !s2_ff.is_wr) ? 1'b1 : (s3_go ? 1'b0 : s3_v_ff);
      s4_v_in = s3_go ? 1'b1 : (rsp_acc ? 1'b0 : s4_v_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff   <= 1'b0;
         s1_v_ff   <= 1'b0;
         s1_cnt_ff <= '0;
         s2_v_ff   <= 1'b0;
         s3_v_ff   <= 1'b0;
         s4_v_ff   <= 1'b0;
      end else begin
         s0_v_ff   <= s0_v_in;
         s1_v_ff   <= s1_v_in;
         s1_cnt_ff <= s1_cnt_in;
         s2_v_ff   <= s2_v_in;
         s3_v_ff   <= s3_v_in;
         s4_v_ff   <= s4_v_in;
      end
   end

   // stage 0
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s0_ff <= trppe_pkg::req_item_type'({req_tuser, req_tdata[68:0]});
      end
   end

   // row preparation into the serialiser
   always_comb begin
      ld_p0 = s0_ff.plane_low;
      ld_p1 = depth_one ? s0_ff.plane_low : s0_ff.plane_high;
      if ((s0_ff.attribute & trppe_pkg::FLIP_MASK) != 8'd0) begin
         ld_p0 = trppe_pkg::mirror8(ld_p0);
         ld_p1 = trppe_pkg::mirror8(ld_p1);
      end
      ld_sel = use_map_ff ? s0_ff.palette_map_value
                          : (s0_ff.attribute & trppe_pkg::PAL_MASK);
      ld_pal = ld_sel - base_palette_ff;
      ld_err = (ld_pal >= trppe_pkg::PAL_LIMIT);
   end

   // stage 1
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_is_wr_ff <= (s0_ff.action == trppe_pkg::ACT_WRITE);
         s1_p0_ff    <= ld_p0;
         s1_p1_ff    <= ld_p1;
         s1_pal_ff   <= ld_pal[trppe_pkg::PAL_W-1:0];
         s1_err_ff   <= ld_err;
         s1_waddr_ff <= s0_ff.color_address;
         s1_wdata_ff <= s0_ff.color_value;
      end else if (s1_emit) begin
         s1_p0_ff <= {s1_p0_ff[6:0], 1'b0};
         s1_p1_ff <= {s1_p1_ff[6:0], 1'b0};
      end
   end

   always_comb begin
      s2_in.is_wr = s1_is_wr_ff;
      s2_in.cid   = {s1_p1_ff[7], s1_p0_ff[7]};
      s2_in.addr  = s1_is_wr_ff ? s1_waddr_ff : {s1_pal_ff, s2_in.cid};
      s2_in.wdata = s1_wdata_ff;
      s2_in.err   = s1_err_ff;
      s2_in.last  = s1_done;
   end

   // stage 2: ram write or read
   always_ff @(posedge clock) begin
      if (s1_emit) begin
         s2_ff <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go && s2_ff.is_wr) begin
         pal_ram[s2_ff.addr] <= s2_ff.wdata;
      end
      if (s2_go && !s2_ff.is_wr) begin
         s3_ff.rdata <= pal_ram[s2_ff.addr];
         s3_ff.addr  <= s2_ff.addr;
         s3_ff.cid   <= s2_ff.cid;
         s3_ff.err   <= s2_ff.err;
         s3_ff.last  <= s2_ff.last;
      end
   end

   // stage 3: pixel format
   always_comb begin
      if (s3_ff.err) begin
         s4_pv_in = 32'd0;
      end else if (pixel_format_ff == trppe_pkg::FMT_GRAY) begin
         s4_pv_in = depth_one ? {31'd0, s3_ff.rdata[24]} : {30'd0, s3_ff.rdata[25:24]};
      end else if (pixel_format_ff == trppe_pkg::FMT_INDEX) begin
         s4_pv_in = 32'(s3_ff.addr);
      end else begin
         s4_pv_in = s3_ff.rdata;
      end
   end

   // stage 4
   always_ff @(posedge clock) begin
      if (s3_go) begin
         s4_cid_ff  <= s3_ff.cid;
         s4_pv_ff   <= s4_pv_in;
         s4_err_ff  <= s3_ff.err;
         s4_last_ff <= s3_ff.last;
      end
   end

   assign rsp_tvalid = s4_v_ff;
   assign rsp_tdata  = {6'd0, s4_pv_ff, s4_cid_ff};
   assign rsp_tuser  = s4_err_ff;
   assign rsp_tlast  = s4_last_ff;

   // checks
   a_cnt_idle : assert property (@(posedge clock) disable iff (reset)
      !s1_v_ff |-> (s1_cnt_ff == '0))
      else $error("row counter not at zero while serialiser empty");

   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[33:2] == 32'd0))
      else $error("pixel value not zero on palette error");

   a_gray_width : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (pixel_format_ff == trppe_pkg::FMT_GRAY))
         |-> (rsp_tdata[33:4] == 30'd0))
      else $error("gray level wider than two bits");

   a_index_width : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (pixel_format_ff == trppe_pkg::FMT_INDEX))
         |-> (rsp_tdata[33:7] == 27'd0))
      else $error("palette index outside ram range");

endmodule
